>>> design/rfoa_pkg.sv
// Shared types, constants and tables for the rotor Fourier operator block.
package rfoa_pkg;

	localparam int VECTOR_DEPTH = 4096;
	localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
	localparam int MAX_ROTORS   = 8;
	localparam int PAIRS        = MAX_ROTORS * (MAX_ROTORS - 1) / 2;
	localparam int PAIR_W       = $clog2(PAIRS);
	localparam int ROT_W        = $clog2(MAX_ROTORS);
	localparam int PLACE_W      = ADDR_W + 1;
	localparam int PIDX_W       = $clog2(MAX_ROTORS + 1);
	localparam int DIST_W       = 9;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [PLACE_W-1:0] PLACE_SAT  = '1;
	localparam logic [PLACE_W-1:0] PLACE_GRID = PLACE_W'(VECTOR_DEPTH);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROTORS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIAG   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS  = 3'd4;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_GRID  = 2'd2;

	// edge mask bit -> rotor pair (j, k), j < k
	localparam logic [ROT_W-1:0] PAIR_J [PAIRS] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4,
		3'd5, 3'd5,
		3'd6};
	localparam logic [ROT_W-1:0] PAIR_K [PAIRS] = '{
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd4, 3'd5, 3'd6, 3'd7,
		3'd5, 3'd6, 3'd7,
		3'd6, 3'd7,
		3'd7};

	typedef enum logic [2:0] {
		S_IDLE, S_PLACE, S_CHECK, S_DIGIT, S_DIAG, S_EDGE, S_DRAIN, S_DONE
	} state_t;

	// one store fetch handed to the multiply-accumulate pipe
	typedef struct packed {
		logic valid;
		logic diag;
	} fetch_t;

endpackage

>>> design/rfoa_if.sv
// Handshake channels for request and result words.
interface rfoa_req_if;
	import rfoa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [ADDR_W-1:0]        index;
	logic signed [31:0]       element_value;
	modport source (output valid, action, index, element_value, input ready);
	modport sink (input valid, action, index, element_value, output ready);
endinterface

interface rfoa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic [1:0]         status;
	logic               saturated;
	modport source (output valid, result_value, status, saturated, input ready);
	modport sink (input valid, result_value, status, saturated, output ready);
endinterface

>>> design/rfoa_ram.sv
// Generic single-port RAM with registered read.
module rfoa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> design/rfoa_mac.sv
// Shared multiply, round and accumulate pipe for store fetches.
module rfoa_mac import rfoa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  fetch_t              issue,
	input  logic signed [31:0]  rd_data,
	input  logic signed [31:0]  diag_coeff,
	input  logic signed [31:0]  cross_coeff,
	input  logic [DIST_W-1:0]   sq_dist,
	output logic signed [63:0]  acc,
	output logic                busy
);
	fetch_t             tag_s1, tag_s2, tag_s3;
	logic signed [63:0] prod_s2;
	logic signed [47:0] rnd_s3;
	logic signed [63:0] acc_q;
	logic signed [31:0] coef;
	logic signed [63:0] biased;
	logic signed [57:0] scaled;

	assign coef   = tag_s1.diag ? diag_coeff : cross_coeff;
	assign biased = prod_s2 + 64'sd32768;
	assign scaled = rnd_s3 * $signed({1'b0, sq_dist});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			acc_q  <= '0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			if (clr) begin
				acc_q <= '0;
			end else if (tag_s3.valid) begin
				acc_q <= acc_q + (tag_s3.diag ? 64'(scaled) : 64'(rnd_s3));
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_data * coef;
		rnd_s3  <= biased[63:16];
	end

	assign acc  = acc_q;
	assign busy = tag_s1.valid | tag_s2.valid | tag_s3.valid;
endmodule

>>> design/rotor_fourier_operator_apply_top.sv
// Top level: sequencer, configuration registers, vector store and result register.
//
//   req - request words: action (0 write element, 1 read operator output), index,
//         element_value. Taken on valid & ready; ready is high only while the
//         sequencer is idle, so one word is in flight at a time.
//   rsp - one result word per request: result_value, status, saturated, held in
//         an output register until taken.
//   cfg - plain write port (cfg_we, cfg_index, cfg_data); write only when idle.
// Steps from accept to result valid (n = effective rotor count):
//   place-value sweep over the n rotors, grid check, result load.
//   write or bad index: these steps only.
//   read adds a binary digit search over the n digits, one diagonal fetch, an
//   edge walk over the 28 pairs (two hops each) and a pipe drain. The shared
//   multiply-round-accumulate pipe and the single store port carry every fetch.
// Reset restores the configuration defaults and clears control state; the store
// has no reset value, so entries must be written before being read.
// If the receiver stalls, the result holds and the block still takes one more
// request; that one waits at its end until the output register frees up.
module rotor_fourier_operator_apply_top import rfoa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rfoa_req_if.sink              req,
	rfoa_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	// configuration
	logic [3:0]         rotors_q;
	logic [2:0]         cutoff_q;
	logic [PAIRS-1:0]   edges_q;
	logic signed [31:0] diag_q, cross_q;

	// item and sequencer state
	state_t              state_q, state_d;
	logic                action_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [31:0]         val_q;
	logic [PAIR_W-1:0]   cnt_q;
	logic                dir_q;
	logic [1:0]          b_q;
	logic [ROT_W-1:0]    j_q;
	logic [3:0]          q_q;
	logic [ADDR_W-1:0]   qp_q, rem_q;
	logic [DIST_W-1:0]   dist_q;
	logic [PLACE_W-1:0]  plc_q [MAX_ROTORS+1];
	logic [MAX_ROTORS-1:0] lo_ok_q, hi_ok_q;
	logic [1:0]          status_q;

	// result register
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [1:0]         out_status_q;
	logic               out_sat_q;

	// derived configuration
	logic [3:0] n_eff;
	logic [2:0] m_eff;
	logic [3:0] radix;
	always_comb begin
		n_eff = rotors_q;
		if (rotors_q < 4'd2) n_eff = 4'd2;
		if (rotors_q > 4'(MAX_ROTORS)) n_eff = 4'(MAX_ROTORS);
		m_eff = (cutoff_q == 3'd0) ? 3'd1 : cutoff_q;
		radix = {m_eff, 1'b1};
	end

	// place value sweep
	logic [PLACE_W+3:0]  plc_prod;
	logic [PLACE_W-1:0]  plc_next;
	logic [PLACE_W-1:0]  grid;
	logic                place_last;
	assign plc_prod   = plc_q[{1'b0, cnt_q[ROT_W-1:0]}] * radix;
	assign plc_next   = (plc_prod > (PLACE_W+4)'(PLACE_SAT)) ? PLACE_SAT
	                    : plc_prod[PLACE_W-1:0];
	assign grid       = plc_q[n_eff];
	assign place_last = ({1'b0, cnt_q[ROT_W-1:0]} + 4'd1) == n_eff;

	// digit search: one bit of the digit per cycle, top digit first
	logic [3:0]         trial;
	logic [PLACE_W+2:0] cand;
	logic               take;
	logic [3:0]         dig;
	logic [ADDR_W-1:0]  qp_new;
	logic [2:0]         dev;
	logic [5:0]         dev_sq;
	always_comb begin
		trial  = q_q | (4'd1 << b_q);
		cand   = (PLACE_W+3)'(qp_q) + ((PLACE_W+3)'(plc_q[{1'b0, j_q}]) << b_q);
		take   = (trial < radix) && (cand <= (PLACE_W+3)'(rem_q));
		dig    = take ? trial : q_q;
		qp_new = take ? cand[ADDR_W-1:0] : qp_q;
		dev    = (dig[2:0] >= m_eff && dig[3] == 1'b0) ? dig[2:0] - m_eff
		         : 3'(4'(m_eff) - dig);
		if (dig >= 4'(m_eff)) dev = 3'(dig - 4'(m_eff));
		dev_sq = dev * dev;
	end

	// edge walk
	logic [ROT_W-1:0]  ej, ek;
	logic              edge_on;
	logic [ADDR_W+1:0] nb_addr;
	always_comb begin
		ej      = PAIR_J[cnt_q];
		ek      = PAIR_K[cnt_q];
		edge_on = edges_q[cnt_q] && ({1'b0, ek} < n_eff) &&
		          (dir_q ? (lo_ok_q[ej] && hi_ok_q[ek]) : (hi_ok_q[ej] && lo_ok_q[ek]));
		nb_addr = dir_q ? ((ADDR_W+2)'(idx_q) - (ADDR_W+2)'(plc_q[{1'b0, ej}]) +
		                   (ADDR_W+2)'(plc_q[{1'b0, ek}]))
		                : ((ADDR_W+2)'(idx_q) + (ADDR_W+2)'(plc_q[{1'b0, ej}]) -
		                   (ADDR_W+2)'(plc_q[{1'b0, ek}]));
	end

	// store and multiply-accumulate
	logic               out_free;
	logic               rd_ok;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [31:0]        ram_rdata;
	fetch_t             issue;
	logic               mac_clr;
	logic signed [63:0] acc;
	logic               mac_busy;

	assign out_free = !out_valid_q || rsp.ready;
	assign rd_ok    = (status_q == STAT_OK) && (action_q == ACT_READ);

	rfoa_ram #(.WIDTH(32), .DEPTH(VECTOR_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (val_q),
		.rdata (ram_rdata)
	);

	rfoa_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (mac_clr),
		.issue       (issue),
		.rd_data     ($signed(ram_rdata)),
		.diag_coeff  (diag_q),
		.cross_coeff (cross_q),
		.sq_dist     (dist_q),
		.acc         (acc),
		.busy        (mac_busy)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req.valid) state_d = S_PLACE;
			S_PLACE: if (place_last) state_d = S_CHECK;
			S_CHECK: begin
				if (grid > PLACE_GRID || (PLACE_W'(idx_q) >= grid) || action_q == ACT_WRITE)
					state_d = S_DONE;
				else
					state_d = S_DIGIT;
			end
			S_DIGIT: if (b_q == 2'd0 && j_q == '0) state_d = S_DIAG;
			S_DIAG:  state_d = S_EDGE;
			S_EDGE:  if (dir_q && cnt_q == PAIR_W'(PAIRS - 1)) state_d = S_DRAIN;
			S_DRAIN: if (!mac_busy) state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		issue     = '0;
		mac_clr   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				mac_clr   = 1'b1;
			end
			S_CHECK: begin
				ram_we = (grid <= PLACE_GRID) && (PLACE_W'(idx_q) < grid) &&
				         action_q == ACT_WRITE;
			end
			S_DIAG: begin
				issue.valid = 1'b1;
				issue.diag  = 1'b1;
			end
			S_EDGE: begin
				ram_addr    = nb_addr[ADDR_W-1:0];
				issue.valid = edge_on;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rotors_q    <= 4'd2;
			cutoff_q    <= 3'd1;
			edges_q     <= PAIRS'(1);
			diag_q      <= 32'sd65536;
			cross_q     <= -32'sd32768;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROTORS: rotors_q <= cfg_data[3:0];
					REG_CUTOFF: cutoff_q <= cfg_data[2:0];
					REG_EDGES:  edges_q  <= cfg_data[PAIRS-1:0];
					REG_DIAG:   diag_q   <= $signed(cfg_data);
					REG_CROSS:  cross_q  <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				action_q <= req.action;
				idx_q    <= req.index;
				val_q    <= req.element_value;
				cnt_q    <= '0;
				plc_q[0] <= PLACE_W'(1);
			end
			S_PLACE: begin
				plc_q[PIDX_W'(cnt_q[ROT_W-1:0]) + PIDX_W'(1)] <= plc_next;
				cnt_q <= cnt_q + PAIR_W'(1);
			end
			S_CHECK: begin
				if (grid > PLACE_GRID) status_q <= STAT_GRID;
				else if (PLACE_W'(idx_q) >= grid) status_q <= STAT_RANGE;
				else status_q <= STAT_OK;
				j_q     <= 3'(n_eff - 4'd1);
				b_q     <= 2'd3;
				q_q     <= '0;
				qp_q    <= '0;
				rem_q   <= idx_q;
				dist_q  <= '0;
				lo_ok_q <= '0;
				hi_ok_q <= '0;
			end
			S_DIGIT: begin
				if (b_q == 2'd0) begin
					lo_ok_q[j_q] <= dig != 4'd0;
					hi_ok_q[j_q] <= (dig + 4'd1) < radix;
					dist_q       <= dist_q + DIST_W'(dev_sq);
					rem_q        <= rem_q - qp_new;
					q_q          <= '0;
					qp_q         <= '0;
					b_q          <= 2'd3;
					j_q          <= j_q - ROT_W'(1);
				end else begin
					q_q  <= dig;
					qp_q <= qp_new;
					b_q  <= b_q - 2'd1;
				end
			end
			S_DIAG: begin
				cnt_q <= '0;
				dir_q <= 1'b0;
			end
			S_EDGE: begin
				dir_q <= !dir_q;
				if (dir_q) cnt_q <= cnt_q + PAIR_W'(1);
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			out_status_q <= status_q;
			if (rd_ok && acc > 64'sd2147483647) begin
				out_value_q <= 32'sh7fffffff;
				out_sat_q   <= 1'b1;
			end else if (rd_ok && acc < -64'sd2147483648) begin
				out_value_q <= 32'sh80000000;
				out_sat_q   <= 1'b1;
			end else begin
				out_value_q <= rd_ok ? acc[31:0] : 32'd0;
				out_sat_q   <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_status_q;
	assign rsp.saturated    = out_sat_q;

	// checks
	a_we_only_check: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CHECK && action_q == ACT_WRITE))
		else $error("store write outside grid check");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mac_busy)
		else $error("mac pipe busy while idle");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q == S_PLACE)
		else $error("accepted word did not start place sweep");
	a_issue_phase: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> (state_q == S_DIAG || state_q == S_EDGE))
		else $error("fetch issued outside fetch phases");
endmodule

>>> verif/rotor_fourier_operator_apply_top_test.sv
// Self-checking testbench for the rotor Fourier operator block.
`timescale 1ns / 1ps

module rotor_fourier_operator_apply_top_test;
	import rfoa_pkg::*;

	localparam int  CLK_HALF    = 6;
	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  DRAIN_WAIT  = 150;   // a bit above the worst read latency
	localparam int  HOLD_CYCLES = 400;
	localparam int  PHASES      = 11;
	localparam int  RAND_ITEMS  = 148;

	typedef struct {
		logic               action;
		logic [ADDR_W-1:0]  index;
		logic signed [31:0] value;
	} req_word_t;

	typedef struct {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic               saturated;
	} rsp_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rfoa_req_if req_ch ();
	rfoa_rsp_if rsp_ch ();

	rotor_fourier_operator_apply_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the configuration and the vector, as the block should hold it
	logic [3:0]         sh_rotors;
	logic [2:0]         sh_cutoff;
	logic [27:0]        sh_edges;
	logic signed [31:0] sh_diag;
	logic signed [31:0] sh_cross;
	logic signed [31:0] vec_mem [VECTOR_DEPTH];
	bit                 loaded  [VECTOR_DEPTH];   // entries the stimulus has written

	req_word_t pending_words[$];
	rsp_word_t expected_results[$];

	int  snd_idle_pct;
	int  rcv_stall_pct;
	int  hold_req_cnt;
	int  errors;
	int  cycles;
	int  n_reads, n_writes, n_sat, n_range, n_grid;
	bit  req_took;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic int eff_rotors();
		if (sh_rotors < 2) return 2;
		if (sh_rotors > MAX_ROTORS) return MAX_ROTORS;
		return sh_rotors;
	endfunction

	function automatic int eff_cutoff();
		return (sh_cutoff == 0) ? 1 : sh_cutoff;
	endfunction

	function automatic longint grid_size();
		longint g;
		g = 1;
		for (int r = 0; r < eff_rotors(); r++) g = g * (2 * eff_cutoff() + 1);
		return g;
	endfunction

	// Q32.32 back to Q16.16, nearest with ties upward
	function automatic longint q16_round(input longint p);
		return (p + 32768) >>> 16;
	endfunction

	// Operator output at idx before saturation; taps lists every store entry it touches
	function automatic longint operator_sum(input int idx, output int taps[$]);
		longint pl [MAX_ROTORS+1];
		int     dg [MAX_ROTORS];
		int     n, m, radix, b, a, t;
		longint dsum, acc, sum;
		n = eff_rotors();
		m = eff_cutoff();
		radix = 2 * m + 1;
		pl[0] = 1;
		for (int r = 0; r < MAX_ROTORS; r++) pl[r+1] = pl[r] * radix;
		taps = {};
		taps.push_back(idx);
		dsum = 0;
		for (int j = 0; j < MAX_ROTORS; j++) begin
			dg[j] = 0;
			if (j < n) begin
				dg[j] = (idx / pl[j]) % radix;
				a = dg[j] - m;
				dsum += a * a;
			end
		end
		acc = q16_round(longint'(sh_diag) * longint'(vec_mem[idx])) * dsum;
		sum = 0;
		b = 0;
		for (int j = 0; j < MAX_ROTORS - 1; j++) begin
			for (int k = j + 1; k < MAX_ROTORS; k++) begin
				if (k < n && sh_edges[b]) begin
					// hop up on digit j, down on digit k, and the mirror of it
					if (dg[j] + 1 < radix && dg[k] >= 1) begin
						t = idx + pl[j] - pl[k];
						taps.push_back(t);
						sum += q16_round(longint'(sh_cross) * longint'(vec_mem[t]));
					end
					if (dg[j] >= 1 && dg[k] + 1 < radix) begin
						t = idx - pl[j] + pl[k];
						taps.push_back(t);
						sum += q16_round(longint'(sh_cross) * longint'(vec_mem[t]));
					end
				end
				b++;
			end
		end
		return acc + sum;
	endfunction

	// Work out the result of one accepted word and update the shadow vector
	function automatic void predict_operator(input req_word_t w);
		rsp_word_t e;
		longint    g, y;
		int        taps[$];
		e = '{result_value: '0, status: STAT_OK, saturated: 1'b0};
		g = grid_size();
		if (g > VECTOR_DEPTH) begin
			e.status = STAT_GRID;
			n_grid++;
		end else if (w.index >= g) begin
			e.status = STAT_RANGE;
			n_range++;
		end else if (w.action == ACT_WRITE) begin
			vec_mem[w.index] = w.value;
			n_writes++;
		end else begin
			y = operator_sum(w.index, taps);
			n_reads++;
			if (y > 64'sd2147483647) begin
				y = 64'sd2147483647;
				e.saturated = 1'b1;
			end else if (y < -64'sd2147483648) begin
				y = -64'sd2147483648;
				e.saturated = 1'b1;
			end
			if (e.saturated) n_sat++;
			e.result_value = y[31:0];
		end
		expected_results.push_back(e);
	endfunction

	// Queue a word; a good read first gets writes for any entry it would touch unwritten
	function automatic void queue_word(input logic act, input int idx, input logic [31:0] val);
		longint g;
		int     taps[$];
		g = grid_size();
		if (g <= VECTOR_DEPTH && idx < g) begin
			if (act == ACT_READ) begin
				void'(operator_sum(idx, taps));
				foreach (taps[i]) begin
					if (!loaded[taps[i]]) begin
						pending_words.push_back('{ACT_WRITE, taps[i][ADDR_W-1:0], $urandom});
						loaded[taps[i]] = 1'b1;
					end
				end
			end else begin
				loaded[idx] = 1'b1;
			end
		end
		pending_words.push_back('{act, idx[ADDR_W-1:0], val});
	endfunction

	function automatic logic [31:0] rand_coeff();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($urandom_range(262143)) - 32'd131072;
		endcase
	endfunction

	function automatic logic [31:0] rand_element();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($urandom_range(1048575)) - 32'd524288;
		endcase
	endfunction

	// Mostly writes and reads inside the grid, the rest anywhere in the index space;
	// count covers the fill writes that reads pull in as well
	function automatic void queue_random(input int count);
		longint g;
		int     r, lim, base;
		g = grid_size();
		lim = (g > VECTOR_DEPTH) ? VECTOR_DEPTH - 1 : int'(g) - 1;
		base = pending_words.size();
		while (pending_words.size() - base < count) begin
			r = $urandom_range(99);
			if (r < 40)
				queue_word(ACT_WRITE, $urandom_range(lim), rand_element());
			else if (r < 88)
				queue_word(ACT_READ, $urandom_range(lim), $urandom);
			else
				queue_word(1'($urandom_range(1)), $urandom_range(VECTOR_DEPTH - 1), $urandom);
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ROTORS: sh_rotors = data[3:0];
			REG_CUTOFF: sh_cutoff = data[2:0];
			REG_EDGES:  sh_edges  = data[27:0];
			REG_DIAG:   sh_diag   = data;
			REG_CROSS:  sh_cross  = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0 ||
			(req_ch.valid && !req_took));
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// Driver: new word at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_took)) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				req_word_t w;
				w = pending_words.pop_front();
				req_ch.valid         <= 1'b1;
				req_ch.action        <= w.action;
				req_ch.index         <= w.index;
				req_ch.element_value <= w.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold-off on request, otherwise random stalls
	int hold_seen;
	int hold_left;
	always @(negedge clk) begin
		if (hold_seen != hold_req_cnt) begin
			hold_seen = hold_req_cnt;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Monitor: predict on request accept, check on result accept
	always @(posedge clk) begin
		req_took = arst_n && req_ch.valid && req_ch.ready;
		if (req_took)
			predict_operator('{req_ch.action, req_ch.index, req_ch.element_value});
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result word with nothing expected: value %h status %0d sat %0d",
					$time, rsp_ch.result_value, rsp_ch.status, rsp_ch.saturated);
				errors++;
			end else begin
				rsp_word_t e;
				e = expected_results.pop_front();
				if (rsp_ch.result_value !== e.result_value) begin
					$display("%0t: result_value expected %h actual %h",
						$time, e.result_value, rsp_ch.result_value);
					errors++;
				end
				if (rsp_ch.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.saturated !== e.saturated) begin
					$display("%0t: saturated expected %0d actual %0d",
						$time, e.saturated, rsp_ch.saturated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d words still pending, %0d results outstanding",
				$time, pending_words.size(), expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Phase configurations: rotors, cutoff; out-of-range values exercise clamping
	int ph_rotors [PHASES] = '{0, 8, 7, 3, 15, 2, 4, 5, 6, 1, 2};
	int ph_cutoff [PHASES] = '{0, 1, 1, 7, 0, 7, 2, 1, 1, 3, 1};

	initial begin
		errors        = 0;
		cycles        = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_req_cnt  = 0;
		hold_seen     = 0;
		hold_left     = 0;
		req_took      = 1'b0;
		{n_reads, n_writes, n_sat, n_range, n_grid} = '0;
		req_ch.valid         = 1'b0;
		req_ch.action        = ACT_WRITE;
		req_ch.index         = '0;
		req_ch.element_value = '0;
		rsp_ch.ready         = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sh_rotors = 4'd2;
		sh_cutoff = 3'd1;
		sh_edges  = 28'd1;
		sh_diag   = 32'sd65536;
		sh_cross  = -32'sd32768;
		foreach (vec_mem[i]) begin
			vec_mem[i] = '0;
			loaded[i]  = 1'b0;
		end

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset configuration (3x3 grid, one edge): extremes and edge cells
		queue_word(ACT_WRITE, 0, 32'h7fff_ffff);
		queue_word(ACT_WRITE, 8, 32'h8000_0000);
		queue_word(ACT_WRITE, 4, 32'hffff_ffff);
		queue_word(ACT_WRITE, 2, 32'h0000_0001);
		queue_word(ACT_WRITE, 6, 32'h0001_8000);
		queue_word(ACT_READ, 0, 32'h0);
		queue_word(ACT_READ, 4, 32'hffff_ffff);
		queue_word(ACT_READ, 8, 32'h0);
		queue_word(ACT_READ, 2, 32'h0);
		queue_word(ACT_READ, 6, 32'h0);
		queue_word(ACT_WRITE, 9, 32'h1234_5678);      // index past grid
		queue_word(ACT_WRITE, 4095, 32'h7fff_ffff);
		queue_word(ACT_READ, 4095, 32'h0);
		queue_word(ACT_READ, 9, 32'h0);
		queue_word(ACT_READ, 4, 32'h0);               // write past grid left store alone
		wait_quiet();

		// Saturation both ways with extreme coefficients on the same grid
		write_reg(REG_DIAG, 32'h7fff_ffff);
		write_reg(REG_CROSS, 32'h8000_0000);
		write_reg(REG_CUTOFF, 3'd1);                   // no-op value, store kept
		queue_word(ACT_READ, 0, 32'h0);
		queue_word(ACT_READ, 8, 32'h0);
		queue_word(ACT_READ, 4, 32'h0);
		wait_quiet();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 85; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 85; end
				default: begin snd_idle_pct = 32; rcv_stall_pct = 32; end
			endcase
			write_reg(REG_ROTORS, ph_rotors[p]);
			write_reg(REG_CUTOFF, ph_cutoff[p]);
			case (p)
				2: write_reg(REG_EDGES, 28'hfff_ffff);
				5: write_reg(REG_EDGES, 28'h0);
				default: write_reg(REG_EDGES, $urandom);
			endcase
			write_reg(REG_DIAG, rand_coeff());
			write_reg(REG_CROSS, rand_coeff());
			// nonexistent register: must be ignored
			write_reg(CFG_IDX_W'(5 + $urandom_range(2)), $urandom);
			// receiver freezes while the sender keeps offering, so the input backs up
			if (p == 2 || p == 7) hold_req_cnt++;
			queue_random(RAND_ITEMS);
			wait_quiet();
		end

		$display("Covered %0d reads (%0d saturated), %0d writes, %0d out-of-grid, %0d oversize",
			n_reads, n_sat, n_writes, n_range, n_grid);
		$display("across %0d configurations and four idle patterns", PHASES + 2);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
design/rfoa_pkg.sv
design/rfoa_if.sv
design/rfoa_ram.sv
design/rfoa_mac.sv
design/rotor_fourier_operator_apply_top.sv
verif/rotor_fourier_operator_apply_top_test.sv
